>>> hw/rtl/biea_pkg.sv
package biea_pkg;

    localparam int DEPTH_DEF = 16;

    localparam int DATA_W = 32;
    localparam int FUNC_W = 4;
    localparam int POS_W  = 5;
    localparam int POSB_W = 4;
    localparam int CNT_W  = 5;
    localparam int ST_W   = 2;

    localparam logic [FUNC_W-1:0] FN_INSERT    = 4'd0;
    localparam logic [FUNC_W-1:0] FN_ERASE     = 4'd1;
    localparam logic [FUNC_W-1:0] FN_PUSH_BACK = 4'd2;
    localparam logic [FUNC_W-1:0] FN_POP_BACK  = 4'd3;
    localparam logic [FUNC_W-1:0] FN_READ      = 4'd4;
    localparam logic [FUNC_W-1:0] FN_SWAP      = 4'd5;
    localparam logic [FUNC_W-1:0] FN_CLEAR     = 4'd6;
    localparam logic [FUNC_W-1:0] FN_RESIZE    = 4'd7;
    localparam logic [FUNC_W-1:0] FN_READ_BACK = 4'd8;

    localparam logic [ST_W-1:0] ST_OK     = 2'd0;
    localparam logic [ST_W-1:0] ST_FULL   = 2'd1;
    localparam logic [ST_W-1:0] ST_BADPOS = 2'd2;

    typedef logic [1:0] t_cell_cmd;

    localparam t_cell_cmd CELL_HOLD  = 2'd0;
    localparam t_cell_cmd CELL_LEFT  = 2'd1;
    localparam t_cell_cmd CELL_RIGHT = 2'd2;
    localparam t_cell_cmd CELL_LOAD  = 2'd3;

    typedef struct packed {
        logic [FUNC_W-1:0]        func;
        logic [POS_W-1:0]         pos;
        logic [POSB_W-1:0]        pos_b;
        logic signed [DATA_W-1:0] value;
        logic [POS_W-1:0]         new_size;
    } t_in_item;

    typedef struct packed {
        logic signed [DATA_W-1:0] read_value;
        logic [CNT_W-1:0]         count;
        logic                     is_empty;
        logic [ST_W-1:0]          status;
    } t_out_item;

endpackage

>>> hw/rtl/biea_cell.sv
module biea_cell (
    input  logic                               i_clk,
    input  biea_pkg::t_cell_cmd                i_cmd,
    input  logic signed [biea_pkg::DATA_W-1:0] i_left,
    input  logic signed [biea_pkg::DATA_W-1:0] i_right,
    input  logic signed [biea_pkg::DATA_W-1:0] i_load,
    output logic signed [biea_pkg::DATA_W-1:0] o_data
);
    import biea_pkg::*;

    logic signed [DATA_W-1:0] r_data;
    logic signed [DATA_W-1:0] n_data;

    always_comb begin
        case (i_cmd)
            CELL_LEFT:  n_data = i_left;
            CELL_RIGHT: n_data = i_right;
            CELL_LOAD:  n_data = i_load;
            default:    n_data = r_data;
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_data <= n_data;
    end

    assign o_data = r_data;

endmodule

>>> hw/rtl/bounded_insert_erase_array_core.sv
// Ordered array of up to DEPTH signed 32-bit entries held in a row of cells, each cell
// holding one entry and taking its left or right neighbour's value so that insert and
// erase move every later entry at once. An item is first captured into a request
// register; then the row is read, status is decided and every cell shifts, loads or
// holds at once; the result then sits in an output register, so the next transaction
// is taken while it waits. A new transaction is not taken until the captured one has
// executed, and execution waits while the output side stalls with a result pending.
// Refused operations leave the array and count unchanged; entries beyond the count
// hold no defined value until written.
module bounded_insert_erase_array_core #(
    parameter int DEPTH = biea_pkg::DEPTH_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_stall,
    input  biea_pkg::t_in_item  i_in_data,
    output logic                o_out_valid,
    input  logic                i_out_stall,
    output biea_pkg::t_out_item o_out_data
);
    import biea_pkg::*;

    localparam int CW = $clog2(DEPTH + 1);
    localparam int XW = (CW > POS_W) ? CW : POS_W;

    logic      r_busy;
    t_in_item  r_req;
    logic [CW-1:0] r_count;
    t_out_item r_out;
    logic      r_out_valid;

    logic w_in_acc;
    logic w_exec;

    logic signed [DATA_W-1:0] w_cell_q [DEPTH];
    t_cell_cmd                w_cmd    [DEPTH];
    logic signed [DATA_W-1:0] w_load   [DEPTH];

    logic [XW-1:0] x_pos;
    logic [XW-1:0] x_posb;
    logic [XW-1:0] x_nsize;
    logic [XW-1:0] x_cnt;
    logic [XW-1:0] x_depth;
    logic [XW-1:0] w_ipos;

    logic signed [DATA_W-1:0] w_rd_a;
    logic signed [DATA_W-1:0] w_rd_b;
    logic signed [DATA_W-1:0] w_rd_last;

    logic w_ins_ok;
    logic w_era_ok;
    logic w_swp_ok;
    logic w_rsz_ok;

    logic [CW-1:0]            n_count;
    logic [ST_W-1:0]          n_status;
    logic signed [DATA_W-1:0] n_rd;

    assign w_in_acc   = i_in_valid && !r_busy;
    assign w_exec     = r_busy && (!r_out_valid || !i_out_stall);
    assign o_in_stall = r_busy;

    assign x_pos   = XW'(r_req.pos);
    assign x_posb  = XW'(r_req.pos_b);
    assign x_nsize = XW'(r_req.new_size);
    assign x_cnt   = XW'(r_count);
    assign x_depth = XW'(DEPTH);
    assign w_ipos  = (r_req.func == FN_PUSH_BACK) ? x_cnt : x_pos;

    // row read
    always_comb begin
        w_rd_a    = '0;
        w_rd_b    = '0;
        w_rd_last = '0;
        for (int i = 0; i < DEPTH; i++) begin
            if (XW'(i) == x_pos) begin
                w_rd_a = w_rd_a | w_cell_q[i];
            end
            if (XW'(i) == x_posb) begin
                w_rd_b = w_rd_b | w_cell_q[i];
            end
            if (XW'(i) == x_cnt - XW'(1)) begin
                w_rd_last = w_rd_last | w_cell_q[i];
            end
        end
    end

    always_comb begin
        n_count  = r_count;
        n_status = ST_OK;
        n_rd     = '0;
        w_ins_ok = 1'b0;
        w_era_ok = 1'b0;
        w_swp_ok = 1'b0;
        w_rsz_ok = 1'b0;
        case (r_req.func)
            FN_INSERT, FN_PUSH_BACK: begin
                if (x_cnt >= x_depth) begin
                    n_status = ST_FULL;
                end else if (w_ipos > x_cnt) begin
                    n_status = ST_BADPOS;
                end else begin
                    w_ins_ok = 1'b1;
                    n_count  = r_count + CW'(1);
                end
            end
            FN_ERASE: begin
                if (x_pos >= x_cnt) begin
                    n_status = ST_BADPOS;
                end else begin
                    w_era_ok = 1'b1;
                    n_count  = r_count - CW'(1);
                end
            end
            FN_POP_BACK: begin
                if (x_cnt == '0) begin
                    n_status = ST_BADPOS;
                end else begin
                    n_count = r_count - CW'(1);
                end
            end
            FN_READ: begin
                if (x_pos >= x_cnt) begin
                    n_status = ST_BADPOS;
                end else begin
                    n_rd = w_rd_a;
                end
            end
            FN_SWAP: begin
                if (x_pos >= x_cnt || x_posb >= x_cnt) begin
                    n_status = ST_BADPOS;
                end else begin
                    w_swp_ok = 1'b1;
                end
            end
            FN_CLEAR: begin
                n_count = '0;
            end
            FN_RESIZE: begin
                if (x_nsize > x_depth) begin
                    n_status = ST_FULL;
                end else begin
                    w_rsz_ok = 1'b1;
                    n_count  = CW'(x_nsize);
                end
            end
            FN_READ_BACK: begin
                if (x_cnt == '0) begin
                    n_status = ST_BADPOS;
                end else begin
                    n_rd = w_rd_last;
                end
            end
            default: begin
                n_status = ST_OK;
            end
        endcase
    end

    // per-cell command
    always_comb begin
        for (int i = 0; i < DEPTH; i++) begin
            w_cmd[i]  = CELL_HOLD;
            w_load[i] = '0;
            if (w_exec) begin
                if (w_ins_ok) begin
                    if (XW'(i) == w_ipos) begin
                        w_cmd[i]  = CELL_LOAD;
                        w_load[i] = r_req.value;
                    end else if (XW'(i) > w_ipos && XW'(i) <= x_cnt) begin
                        w_cmd[i] = CELL_LEFT;
                    end
                end
                if (w_era_ok && XW'(i) >= x_pos && XW'(i) + XW'(1) < x_cnt) begin
                    w_cmd[i] = CELL_RIGHT;
                end
                if (w_swp_ok) begin
                    if (XW'(i) == x_pos) begin
                        w_cmd[i]  = CELL_LOAD;
                        w_load[i] = w_rd_b;
                    end else if (XW'(i) == x_posb) begin
                        w_cmd[i]  = CELL_LOAD;
                        w_load[i] = w_rd_a;
                    end
                end
                if (w_rsz_ok && XW'(i) >= x_cnt && XW'(i) < x_nsize) begin
                    w_cmd[i] = CELL_LOAD;
                end
            end
        end
    end

    for (genvar g = 0; g < DEPTH; g++) begin : g_cell
        logic signed [DATA_W-1:0] w_left;
        logic signed [DATA_W-1:0] w_right;
        if (g == 0) begin : g_first
            assign w_left = '0;
        end else begin : g_mid_l
            assign w_left = w_cell_q[g-1];
        end
        if (g == DEPTH - 1) begin : g_last
            assign w_right = '0;
        end else begin : g_mid_r
            assign w_right = w_cell_q[g+1];
        end
        biea_cell u_cell (
            .i_clk   (i_clk),
            .i_cmd   (w_cmd[g]),
            .i_left  (w_left),
            .i_right (w_right),
            .i_load  (w_load[g]),
            .o_data  (w_cell_q[g])
        );
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy      <= 1'b0;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (w_in_acc) begin
                r_busy <= 1'b1;
            end else if (w_exec) begin
                r_busy <= 1'b0;
            end
            if (w_exec) begin
                r_count     <= n_count;
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_acc) begin
            r_req <= i_in_data;
        end
        if (w_exec) begin
            r_out.read_value <= n_rd;
            r_out.count      <= CNT_W'(n_count);
            r_out.is_empty   <= (n_count == '0);
            r_out.status     <= n_status;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        x_cnt <= x_depth)
        else $error("live count beyond depth");

    a_refused_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_exec && n_status != ST_OK) |=> $stable(r_count))
        else $error("refused transaction changed count");

    a_insert_grows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_exec && w_ins_ok) |=> (x_cnt == $past(x_cnt) + XW'(1)))
        else $error("insert did not grow count");

    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_in_acc |=> r_busy)
        else $error("accepted transaction not held");

    a_exec_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_exec |=> (r_out_valid && !r_busy))
        else $error("executed transaction gave no result");

endmodule

>>> tb/sv/tb.sv
`timescale 1ns / 100ps

module tb;

    import biea_pkg::*;

    localparam int DEPTH = DEPTH_DEF;

    localparam logic [FUNC_W-1:0] FN_UNUSED_LO = 4'd9;
    localparam logic [FUNC_W-1:0] FN_UNUSED_HI = 4'd15;

    logic      i_clk = 1'b0;
    logic      i_rst_n = 1'b0;
    logic      i_in_valid = 1'b0;
    logic      o_in_stall;
    t_in_item  i_in_data = '0;
    logic      o_out_valid;
    logic      i_out_stall = 1'b0;
    t_out_item o_out_data;

    logic signed [DATA_W-1:0] shadow_entries [DEPTH];
    int                       shadow_count = 0;
    t_out_item                pending_results [$];
    t_out_item                want;

    int src_idle_pct = 0;
    int sink_idle_pct = 0;
    int items_sent = 0;
    int results_checked = 0;
    int mismatch_count = 0;
    int error_count = 0;

    bounded_insert_erase_array_core uut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data)
    );

    always #4 i_clk = ~i_clk;

    function automatic t_out_item predict_array_op(t_in_item it);
        t_out_item                r;
        int                       p;
        int                       i;
        logic signed [DATA_W-1:0] t;
        r = '0;
        r.status = ST_OK;
        p = int'(it.pos);
        case (it.func)
            FN_INSERT, FN_PUSH_BACK: begin
                if (it.func == FN_PUSH_BACK)
                    p = shadow_count;
                if (shadow_count >= DEPTH) begin
                    r.status = ST_FULL;
                end else if (p > shadow_count) begin
                    r.status = ST_BADPOS;
                end else begin
                    for (i = shadow_count; i > p; i--)
                        shadow_entries[i] = shadow_entries[i-1];
                    shadow_entries[p] = it.value;
                    shadow_count++;
                end
            end
            FN_POP_BACK: begin
                if (shadow_count == 0)
                    r.status = ST_BADPOS;
                else
                    shadow_count--;
            end
            FN_ERASE: begin
                if (p >= shadow_count) begin
                    r.status = ST_BADPOS;
                end else begin
                    for (i = p; i + 1 < shadow_count; i++)
                        shadow_entries[i] = shadow_entries[i+1];
                    shadow_count--;
                end
            end
            FN_READ: begin
                if (p >= shadow_count)
                    r.status = ST_BADPOS;
                else
                    r.read_value = shadow_entries[p];
            end
            FN_SWAP: begin
                if (p >= shadow_count || int'(it.pos_b) >= shadow_count) begin
                    r.status = ST_BADPOS;
                end else begin
                    t = shadow_entries[p];
                    shadow_entries[p] = shadow_entries[it.pos_b];
                    shadow_entries[it.pos_b] = t;
                end
            end
            FN_CLEAR: begin
                shadow_count = 0;
            end
            FN_RESIZE: begin
                if (int'(it.new_size) > DEPTH) begin
                    r.status = ST_FULL;
                end else begin
                    for (i = shadow_count; i < int'(it.new_size); i++)
                        shadow_entries[i] = '0;
                    shadow_count = int'(it.new_size);
                end
            end
            FN_READ_BACK: begin
                if (shadow_count == 0)
                    r.status = ST_BADPOS;
                else
                    r.read_value = shadow_entries[shadow_count-1];
            end
            default: begin
            end
        endcase
        r.count = shadow_count[CNT_W-1:0];
        r.is_empty = (shadow_count == 0);
        return r;
    endfunction

    function automatic t_in_item mk(logic [FUNC_W-1:0] f, int p, int pb,
                                    logic signed [DATA_W-1:0] v, int ns);
        t_in_item it;
        it.func = f;
        it.pos = p[POS_W-1:0];
        it.pos_b = pb[POSB_W-1:0];
        it.value = v;
        it.new_size = ns[POS_W-1:0];
        return it;
    endfunction

    function automatic logic signed [DATA_W-1:0] rand_value();
        case ($urandom_range(19))
            0: return 32'sh8000_0000;
            1: return 32'sh7fff_ffff;
            2: return -32'sd1;
            3: return '0;
            default: return $urandom;
        endcase
    endfunction

    function automatic t_in_item rand_item();
        t_in_item it;
        int       sel;
        int       top;
        it.func = FUNC_W'($urandom_range(15));
        it.pos = POS_W'($urandom_range(31));
        it.pos_b = POSB_W'($urandom_range(15));
        it.value = rand_value();
        it.new_size = POS_W'($urandom_range(31));
        top = (shadow_count > 0) ? shadow_count - 1 : 0;
        if ($urandom_range(99) >= 10) begin
            sel = $urandom_range(99);
            if (sel < 20) begin
                it.func = FN_INSERT;
                it.pos = POS_W'($urandom_range(shadow_count));
            end else if (sel < 34) begin
                it.func = FN_PUSH_BACK;
            end else if (sel < 46) begin
                it.func = FN_ERASE;
                it.pos = POS_W'($urandom_range(top));
            end else if (sel < 53) begin
                it.func = FN_POP_BACK;
            end else if (sel < 69) begin
                it.func = FN_READ;
                it.pos = POS_W'($urandom_range(top));
            end else if (sel < 79) begin
                it.func = FN_SWAP;
                it.pos = POS_W'($urandom_range(top));
                it.pos_b = POSB_W'($urandom_range(top));
            end else if (sel < 81) begin
                it.func = FN_CLEAR;
            end else if (sel < 89) begin
                it.func = FN_RESIZE;
                it.new_size = POS_W'($urandom_range(DEPTH));
            end else begin
                it.func = FN_READ_BACK;
            end
        end
        return it;
    endfunction

    task automatic send_item(t_in_item it);
        while ($urandom_range(99) < src_idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_data <= it;
        do
            @(posedge i_clk);
        while (o_in_stall);
        pending_results.push_back(predict_array_op(it));
        items_sent++;
    endtask

    // result checker
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (o_out_valid && !i_out_stall) begin
                if (pending_results.size() == 0) begin
                    error_count++;
                    $display("unexpected result: value %0d count %0d empty %0b status %0d",
                             o_out_data.read_value, o_out_data.count,
                             o_out_data.is_empty, o_out_data.status);
                end else begin
                    want = pending_results.pop_front();
                    results_checked++;
                    if (o_out_data.read_value !== want.read_value ||
                        o_out_data.count !== want.count ||
                        o_out_data.is_empty !== want.is_empty ||
                        o_out_data.status !== want.status) begin
                        mismatch_count++;
                        if (mismatch_count <= 10) begin
                            $write("mismatch at transaction %0d: exp value %0d count %0d",
                                   results_checked, want.read_value, want.count);
                            $write(" empty %0b status %0d", want.is_empty, want.status);
                            $display(", got value %0d count %0d empty %0b status %0d",
                                     o_out_data.read_value, o_out_data.count,
                                     o_out_data.is_empty, o_out_data.status);
                        end
                    end
                end
            end
            i_out_stall <= ($urandom_range(99) < sink_idle_pct);
        end
    end

    task automatic test_empty_refusals();
        send_item(mk(FN_READ_BACK, 0, 0, 0, 0));
        send_item(mk(FN_POP_BACK, 0, 0, 0, 0));
        send_item(mk(FN_ERASE, 0, 0, 0, 0));
        send_item(mk(FN_SWAP, 0, 0, 0, 0));
        send_item(mk(FN_INSERT, 1, 0, 5, 0));
    endtask

    task automatic test_insert_order();
        send_item(mk(FN_INSERT, 0, 0, 32'sh8000_0000, 0));
        send_item(mk(FN_PUSH_BACK, 0, 0, 32'sh7fff_ffff, 0));
        send_item(mk(FN_INSERT, 1, 0, -32'sd1, 0));
        send_item(mk(FN_INSERT, 4, 0, 7, 0));
        send_item(mk(FN_READ, 2, 0, 0, 0));
        send_item(mk(FN_READ, 31, 0, 0, 0));
        send_item(mk(FN_SWAP, 0, 2, 0, 0));
        send_item(mk(FN_ERASE, 1, 0, 0, 0));
        send_item(mk(FN_READ_BACK, 0, 0, 0, 0));
    endtask

    task automatic test_full_refusals();
        send_item(mk(FN_RESIZE, 0, 0, 0, DEPTH));
        send_item(mk(FN_PUSH_BACK, 0, 0, 32'sh1234_5678, 0));
        send_item(mk(FN_INSERT, 31, 15, 9, 0));
        send_item(mk(FN_ERASE, 15, 0, 0, 0));
        send_item(mk(FN_INSERT, 15, 0, 32'sh5a5a_5a5a, 0));
    endtask

    task automatic test_resize_edges();
        send_item(mk(FN_RESIZE, 0, 0, 0, DEPTH + 1));
        send_item(mk(FN_RESIZE, 0, 0, 0, 31));
        send_item(mk(FN_RESIZE, 0, 0, 0, 0));
        send_item(mk(FN_RESIZE, 0, 0, 0, 3));
        send_item(mk(FN_READ, 2, 0, 0, 0));
        send_item(mk(FN_CLEAR, 0, 0, 0, 0));
    endtask

    task automatic test_unused_codes();
        send_item(mk(FN_UNUSED_LO, 0, 0, 1, 1));
        send_item(mk(FN_UNUSED_HI, 31, 15, -32'sd1, 31));
    endtask

    task automatic test_random_mix(int src_pct, int sink_pct, int n);
        src_idle_pct = src_pct;
        sink_idle_pct = sink_pct;
        repeat (n) send_item(rand_item());
    endtask

    initial begin
        src_idle_pct = 12;
        sink_idle_pct = 79;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_empty_refusals();
        test_insert_order();
        test_full_refusals();
        test_resize_edges();
        test_unused_codes();
        test_random_mix(12, 79, 200);
        test_random_mix(79, 12, 200);
        test_random_mix(0, 0, 200);

        i_in_valid <= 1'b0;
        wait (pending_results.size() == 0);
        repeat (8) @(posedge i_clk);

        $display("sent %0d transactions covering every operation, refusal and unused code",
                 items_sent);
        $display("checked %0d results: %0d mismatches, %0d unexpected",
                 results_checked, mismatch_count, error_count);
        if (mismatch_count == 0 && error_count == 0 && pending_results.size() == 0)
            $display("tb: clean");
        else
            $display("tb: errors");
        $finish;
    end

    initial begin
        #2ms;
        $display("tb: errors");
        $finish;
    end

endmodule

>>> sim.f
hw/rtl/biea_pkg.sv
hw/rtl/biea_cell.sv
hw/rtl/bounded_insert_erase_array_core.sv
tb/sv/tb.sv
